FILE: rtl/core/arpsd_pkg.sv
// ----------------------------------------------------------------------------
// arpsd_pkg
// Shared types and constants for the ARP spoofing detector.
// ----------------------------------------------------------------------------
package arpsd_pkg;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic CFG_WINDOW    = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic KIND_BINDING = 1'b0;
  localparam logic KIND_STORM   = 1'b1;

  localparam logic [31:0] WINDOW_RESET    = 32'd1000;
  localparam logic [15:0] THRESHOLD_RESET = 16'd10;

  typedef struct packed {
    logic        is_arp_packet;
    logic [15:0] arp_op;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] sender_mac;
    logic [47:0] target_mac;
    logic [31:0] time_ms;
  } arp_in_t;

  typedef struct packed {
    logic        alert_valid;
    logic        alert_kind;
    logic [31:0] alert_ip;
    logic [47:0] alert_mac;
    logic        table_overflow;
  } arp_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture packet, clear scan state
    logic bind_scan;  // examine binding entry at scan index
    logic bind_done;  // apply binding decision
    logic storm_scan; // examine storm entry at scan index
    logic storm_done; // apply storm decision
    logic emit;       // drive the result
  } arpsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ignore;     // packet is not considered
    logic bind_last;  // scan index at last binding entry
    logic storm_last; // scan index at last storm entry
    logic bind_alert; // binding change found
    logic grat;       // packet is gratuitous
  } arpsd_sts_t;

endpackage

FILE: rtl/core/arpsd_datapath.sv
// ----------------------------------------------------------------------------
// arpsd_datapath
// Binding and storm tables with the compare logic for one entry per cycle.
// ----------------------------------------------------------------------------
module arpsd_datapath #(
  parameter int BINDING_ENTRIES = 64,
  parameter int STORM_ENTRIES   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  arpsd_pkg::arp_in_t   pkt_in,
  input  arpsd_pkg::arpsd_cmd_t cmd,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data,
  output arpsd_pkg::arpsd_sts_t sts,
  output arpsd_pkg::arp_out_t  res,
  output logic                 res_strobe
);
  import arpsd_pkg::*;

  localparam int BW = $clog2(BINDING_ENTRIES);
  localparam int SW = $clog2(STORM_ENTRIES);
  localparam int CW = (BW > SW) ? BW : SW;

  arp_in_t     pkt;
  logic [31:0] window_len;
  logic [15:0] threshold;

  logic [BINDING_ENTRIES-1:0] bvalid;
  logic [31:0] bip  [BINDING_ENTRIES];
  logic [47:0] bmac [BINDING_ENTRIES];
  logic [STORM_ENTRIES-1:0] svalid;
  logic [47:0] smac [STORM_ENTRIES];
  logic [31:0] sstart [STORM_ENTRIES];
  logic [15:0] scount [STORM_ENTRIES];
  logic [STORM_ENTRIES-1:0] salerted;

  logic [CW-1:0] idx, idx_next;
  logic          hit_found, free_found, overflow, alert, kind;
  logic [CW-1:0] hit_idx, free_idx;
  logic [47:0]   hit_mac;

  logic [BW-1:0] bidx;
  logic [SW-1:0] sidx;
  assign bidx = idx[BW-1:0];
  assign sidx = idx[SW-1:0];

  // scan index after this edge, also the binding read address
  always_comb begin
    idx_next = idx;
    if (cmd.load || cmd.bind_done) idx_next = '0;
    else if (cmd.bind_scan) idx_next = sts.bind_last ? '0 : idx + CW'(1);
    else if (cmd.storm_scan) idx_next = sts.storm_last ? '0 : idx + CW'(1);
  end

  // binding memory: registered read one entry ahead of the scan
  logic [31:0]   bip_rd;
  logic [47:0]   bmac_rd;
  logic          bind_new, bind_chg;
  logic [BW-1:0] bind_waddr;
  assign bind_new   = !hit_found && free_found;
  assign bind_chg   = hit_found && (hit_mac != pkt.sender_mac);
  assign bind_waddr = hit_found ? hit_idx[BW-1:0] : free_idx[BW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.bind_done && bind_new) bip[bind_waddr] <= pkt.sender_ip;
    if (cmd.bind_done && (bind_new || bind_chg)) bmac[bind_waddr] <= pkt.sender_mac;
    bip_rd  <= bip[idx_next[BW-1:0]];
    bmac_rd <= bmac[idx_next[BW-1:0]];
  end

  logic b_match, s_match;
  assign b_match = bvalid[bidx] && (bip_rd == pkt.sender_ip);
  assign s_match = svalid[sidx] && (smac[sidx] == pkt.sender_mac);

  logic [SW-1:0] sh;
  assign sh = hit_idx[SW-1:0];

  // storm entry update, evaluated at storm_done
  logic [15:0] cnt_base, cnt_new;
  logic        alerted_base, expired;
  logic [31:0] age;
  always_comb begin
    age = pkt.time_ms - sstart[sh];
    expired = age >= window_len;
    if (!hit_found || expired) begin
      cnt_base = '0;
      alerted_base = 1'b0;
    end else begin
      cnt_base = scount[sh];
      alerted_base = salerted[sh];
    end
    cnt_new = (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;
  end

  logic [SW-1:0] snew;
  assign snew = hit_found ? sh : free_idx[SW-1:0];

  assign sts.ignore = !pkt.is_arp_packet || pkt.sender_ip == '0 ||
                      (pkt.arp_op != OP_REQUEST && pkt.arp_op != OP_REPLY);
  assign sts.bind_last  = (idx == CW'(BINDING_ENTRIES - 1));
  assign sts.storm_last = (idx == CW'(STORM_ENTRIES - 1));
  assign sts.bind_alert = alert;
  assign sts.grat = (pkt.arp_op == OP_REPLY && pkt.target_mac == '0) ||
                    (pkt.arp_op == OP_REQUEST && pkt.sender_ip == pkt.target_ip);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
      threshold  <= THRESHOLD_RESET;
      bvalid     <= '0;
      svalid     <= '0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= cmd.emit;
      idx        <= idx_next;
      if (cfg_valid) begin
        if (cfg_index == CFG_WINDOW) window_len <= cfg_data;
        else threshold <= cfg_data[15:0];
      end
      if (cmd.load) begin
        pkt        <= pkt_in;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        overflow   <= 1'b0;
        alert      <= 1'b0;
        kind       <= KIND_BINDING;
      end
      if (cmd.bind_scan) begin
        if (!hit_found && b_match) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
          hit_mac   <= bmac_rd;
        end
        if (!free_found && !bvalid[bidx]) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
      end
      if (cmd.bind_done) begin
        if (bind_chg) begin
          alert <= 1'b1;
        end else if (bind_new) begin
          bvalid[free_idx[BW-1:0]] <= 1'b1;
        end else if (!hit_found) begin
          overflow <= 1'b1;
        end
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.storm_scan) begin
        if (!hit_found && s_match) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
        end
        if (!free_found && !svalid[sidx]) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
      end
      if (cmd.storm_done) begin
        if (!hit_found && !free_found) begin
          overflow <= 1'b1;
        end else begin
          svalid[snew] <= 1'b1;
          smac[snew]   <= pkt.sender_mac;
          scount[snew] <= cnt_new;
          if (!hit_found || expired) sstart[snew] <= pkt.time_ms;
          if ({16'd0, cnt_new} >= {16'd0, threshold} && !alerted_base) begin
            salerted[snew] <= 1'b1;
            alert <= 1'b1;
            kind  <= KIND_STORM;
          end else begin
            salerted[snew] <= alerted_base;
          end
        end
      end
    end
  end

  always_comb begin
    res = '0;
    if (!sts.ignore) begin
      res.alert_valid    = alert;
      res.alert_kind     = alert ? kind : 1'b0;
      res.alert_ip       = alert ? pkt.sender_ip : '0;
      res.alert_mac      = alert ? pkt.sender_mac : '0;
      res.table_overflow = overflow;
    end
  end

endmodule

FILE: rtl/core/arpsd_ctrl.sv
// ----------------------------------------------------------------------------
// arpsd_ctrl
// Sequencer for one packet: binding scan, storm scan, result.
// ----------------------------------------------------------------------------
module arpsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  arpsd_pkg::arpsd_sts_t sts,
  output arpsd_pkg::arpsd_cmd_t cmd,
  output logic                  busy
);
  import arpsd_pkg::*;

  typedef enum logic [2:0] {
    IDLE, CHECK, BSCAN, BDONE, SSCAN, SDONE, EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load       = start && state == IDLE;
    cmd.bind_scan  = state == BSCAN;
    cmd.bind_done  = state == BDONE;
    cmd.storm_scan = state == SSCAN;
    cmd.storm_done = state == SDONE;
    cmd.emit       = state == EMIT;
  end

  assign busy = state != IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:  if (start) state <= CHECK;
        CHECK: state <= sts.ignore ? EMIT : BSCAN;
        BSCAN: if (sts.bind_last) state <= BDONE;
        BDONE: state <= SSCAN;
        SSCAN: begin
          // binding change or non-gratuitous packet skips the storm table
          if (sts.bind_alert || !sts.grat) state <= EMIT;
          else if (sts.storm_last) state <= SDONE;
        end
        SDONE: state <= EMIT;
        EMIT:  state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == CHECK) else $error("load not followed by check");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    state == EMIT |=> state == IDLE) else $error("emit lasted");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == BSCAN || state == SSCAN) |-> busy) else $error("scan while idle");

endmodule

FILE: rtl/core/arp_spoof_detector_top.sv
// ----------------------------------------------------------------------------
// arp_spoof_detector_top
// ARP spoofing detector: binding-change and gratuitous storm alerts.
// ----------------------------------------------------------------------------
// A packet is taken when start is high and busy low. Each packet gives one
// result on the result ports for one cycle with done high; the receiver
// cannot stall. An ignored packet skips both table scans; otherwise the
// binding table is scanned one entry a cycle, then for a gratuitous packet
// with no binding change the storm table one entry a cycle. Busy stays high
// until a packet is through, so no new packet is taken before then. Each
// table has a single-entry compare.
// Configuration writes are always ready.
module arp_spoof_detector_top #(
  parameter int BINDING_ENTRIES = 64,
  parameter int STORM_ENTRIES   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  arpsd_pkg::arp_in_t  pkt,
  output logic                done,
  output arpsd_pkg::arp_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import arpsd_pkg::*;

  arpsd_cmd_t cmd;
  arpsd_sts_t sts;

  assign cfg_ready = 1'b1;

  arpsd_ctrl u_ctrl (
    .clk, .rst, .start, .sts, .cmd, .busy
  );

  arpsd_datapath #(
    .BINDING_ENTRIES(BINDING_ENTRIES),
    .STORM_ENTRIES(STORM_ENTRIES)
  ) u_dp (
    .clk, .rst, .pkt_in(pkt), .cmd, .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index, .cfg_data, .sts, .res(result), .res_strobe(done)
  );

endmodule
